### rtl/core/vrpft_pkg.sv
`default_nettype none

package vrpft_pkg;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_WRITE    = 2'd1,
        KIND_READ     = 2'd2,
        KIND_TRANSFER = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REG_CONTROL     = 3'd0,
        REG_MASK        = 3'd1,
        REG_STATUS      = 3'd2,
        REG_SPRITE_ADDR = 3'd3,
        REG_SPRITE_DATA = 3'd4,
        REG_SCROLL      = 3'd5,
        REG_ADDRESS     = 3'd6,
        REG_DATA        = 3'd7
    } t_reg;

    typedef struct packed {
        t_kind      kind;
        t_reg       reg_select;
        logic [7:0] write_value;
        logic [7:0] tick_dots;
        logic [7:0] transfer_index;
        logic [7:0] memory_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_value;
        logic        mem_write_enable;
        logic [13:0] mem_address;
        logic [7:0]  mem_write_byte;
        logic [13:0] next_video_address;
        logic        interrupt_line;
        logic        blank_start;
        logic        frame_done;
    } t_out_item;

    typedef struct packed {
        logic       en;
        logic [7:0] idx;
        logic [7:0] data;
    } t_spr_wr;

    localparam int PALETTE_ENTRIES = 32;
    localparam logic [9:0]  DOTS_PER_LINE   = 10'd341;
    localparam logic [8:0]  BLANK_LINE      = 9'd241;
    localparam logic [8:0]  LINES_PER_FRAME = 9'd262;
    localparam logic [13:0] PALETTE_BASE    = 14'h3F00;
    localparam int BIT_VBLANK = 7;
    localparam int BIT_HIT    = 6;
    localparam int BIT_NMI_EN = 7;

    function automatic logic [4:0] f_pal_index(input logic [13:0] addr);
        logic [4:0] idx;
        idx = addr[4:0];
        if (idx[4] && (idx[1:0] == 2'b00)) begin
            idx[4] = 1'b0;
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/core/vrpft_spr_mem.sv
`default_nettype none

module vrpft_spr_mem #(
    parameter int SPRITE_ENTRIES = 256
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  vrpft_pkg::t_spr_wr   i_wr,
    input  wire                  i_rd_en,
    input  wire  [7:0]           i_rd_idx,
    output logic [7:0]           o_rd_data
);
    import vrpft_pkg::*;

    localparam int AW = $clog2(SPRITE_ENTRIES);
    localparam logic [8:0] ENT = 9'(SPRITE_ENTRIES);

    function automatic logic [AW-1:0] f_wrap(input logic [7:0] idx);
        logic [8:0] v;
        v = {1'b0, idx};
        for (int k = 0; k < 3; k++) begin
            if (v >= ENT) begin
                v = v - ENT;
            end
        end
        return v[AW-1:0];
    endfunction

    logic [7:0]          r_mem [0:SPRITE_ENTRIES-1];
    logic [SPRITE_ENTRIES-1:0] r_vld;
    logic [7:0]          r_rd;
    logic [AW-1:0]       w_wr_a;
    logic [AW-1:0]       w_rd_a;

    assign w_wr_a = f_wrap(i_wr.idx);
    assign w_rd_a = f_wrap(i_rd_idx);
    assign o_rd_data = r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[w_wr_a] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[w_wr_a] <= 1'b1;
        end
    end

    // A write in the same cycle as the read is forwarded to the read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (w_wr_a == w_rd_a)) begin
                r_rd <= i_wr.data;
            end else if (r_vld[w_rd_a]) begin
                r_rd <= r_mem[w_rd_a];
            end else begin
                r_rd <= 8'd0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/vrpft_regs.sv
`default_nettype none

module vrpft_regs (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_go,
    input  vrpft_pkg::t_in_item   i_item,
    input  wire  [7:0]            i_spr_rd,
    output vrpft_pkg::t_out_item  o_res,
    output vrpft_pkg::t_spr_wr    o_spr_wr,
    output logic [7:0]            o_next_ptr
);
    import vrpft_pkg::*;

    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_ptr, n_ptr;
    logic [7:0]  r_pal [0:PALETTE_ENTRIES-1];
    logic        n_pal_we;
    logic [13:0] r_va, n_va;
    logic        r_high, n_high;
    logic [9:0]  r_dot, n_dot;
    logic [8:0]  r_line, n_line;
    logic        r_irq, n_irq;
    logic [10:0] w_dsum;
    logic [4:0]  w_pidx;

    assign w_dsum = {1'b0, r_dot} + {3'd0, i_item.tick_dots};
    assign w_pidx = f_pal_index(r_va);
    assign o_next_ptr = n_ptr;

    always_comb begin
        n_ctrl = r_ctrl;
        n_status = r_status;
        n_ptr = r_ptr;
        n_pal_we = 1'b0;
        n_va = r_va;
        n_high = r_high;
        n_dot = r_dot;
        n_line = r_line;
        n_irq = r_irq;
        o_res = '0;
        o_spr_wr = '0;
        o_spr_wr.data = i_item.write_value;
        case (i_item.kind)
            KIND_TICK: begin
                n_dot = w_dsum[9:0];
                if (w_dsum >= {1'b0, DOTS_PER_LINE}) begin
                    n_dot = 10'(w_dsum - {1'b0, DOTS_PER_LINE});
                    n_line = r_line + 9'd1;
                    if (n_line == BLANK_LINE) begin
                        n_status[BIT_VBLANK] = 1'b1;
                        n_status[BIT_HIT] = 1'b0;
                        if (r_ctrl[BIT_NMI_EN]) begin
                            n_irq = 1'b1;
                        end
                        o_res.blank_start = 1'b1;
                    end
                    if (n_line >= LINES_PER_FRAME) begin
                        n_line = 9'd0;
                        n_irq = 1'b0;
                        n_status[BIT_VBLANK] = 1'b0;
                        n_status[BIT_HIT] = 1'b0;
                        o_res.frame_done = 1'b1;
                    end
                end
            end
            KIND_WRITE: begin
                case (i_item.reg_select)
                    REG_CONTROL: begin
                        if (!r_ctrl[BIT_NMI_EN] && i_item.write_value[BIT_NMI_EN]
                            && r_status[BIT_VBLANK]) begin
                            n_irq = 1'b1;
                        end
                        n_ctrl = i_item.write_value;
                    end
                    REG_SPRITE_ADDR: begin
                        n_ptr = i_item.write_value;
                    end
                    REG_SPRITE_DATA: begin
                        o_spr_wr.en = 1'b1;
                        o_spr_wr.idx = r_ptr;
                        n_ptr = r_ptr + 8'd1;
                    end
                    REG_ADDRESS: begin
                        if (r_high) begin
                            n_va = {i_item.write_value[5:0], r_va[7:0]};
                        end else begin
                            n_va = {r_va[13:8], i_item.write_value};
                        end
                        n_high = !r_high;
                    end
                    REG_DATA: begin
                        if (r_va < PALETTE_BASE) begin
                            o_res.mem_write_enable = 1'b1;
                            o_res.mem_address = r_va;
                            o_res.mem_write_byte = i_item.write_value;
                        end else begin
                            n_pal_we = 1'b1;
                        end
                        n_va = r_va + 14'd1;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_READ: begin
                case (i_item.reg_select)
                    REG_STATUS: begin
                        o_res.read_value = r_status;
                        n_status[BIT_VBLANK] = 1'b0;
                        n_high = 1'b1;
                    end
                    REG_SPRITE_DATA: begin
                        o_res.read_value = i_spr_rd;
                    end
                    REG_DATA: begin
                        if (r_va < PALETTE_BASE) begin
                            o_res.read_value = i_item.memory_byte;
                        end else begin
                            o_res.read_value = r_pal[w_pidx];
                        end
                        n_va = r_va + 14'd1;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_TRANSFER: begin
                o_spr_wr.en = 1'b1;
                o_spr_wr.idx = i_item.transfer_index;
                n_ptr = r_ptr + 8'd1;
            end
            default: begin
            end
        endcase
        o_res.next_video_address = n_va;
        o_res.interrupt_line = n_irq;
        if (!i_go) begin
            n_ctrl = r_ctrl;
            n_status = r_status;
            n_ptr = r_ptr;
            n_pal_we = 1'b0;
            n_va = r_va;
            n_high = r_high;
            n_dot = r_dot;
            n_line = r_line;
            n_irq = r_irq;
            o_spr_wr.en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
            r_status <= '0;
            r_ptr <= '0;
            r_va <= '0;
            r_high <= 1'b1;
            r_dot <= '0;
            r_line <= '0;
            r_irq <= 1'b0;
            for (int i = 0; i < PALETTE_ENTRIES; i++) begin
                r_pal[i] <= 8'd0;
            end
        end else begin
            r_ctrl <= n_ctrl;
            r_status <= n_status;
            r_ptr <= n_ptr;
            r_va <= n_va;
            r_high <= n_high;
            r_dot <= n_dot;
            r_line <= n_line;
            r_irq <= n_irq;
            if (n_pal_we) begin
                r_pal[w_pidx] <= i_item.write_value;
            end
        end
    end

    a_dot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot < DOTS_PER_LINE)
        else $error("Dot counter has left its line.");

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line < LINES_PER_FRAME)
        else $error("Line counter has left its frame.");

    a_irq_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_irq) |-> r_ctrl[BIT_NMI_EN])
        else $error("Interrupt raised while it is disabled.");

endmodule

`default_nettype wire

### rtl/core/video_register_port_and_frame_timer.sv
`default_nettype none

// Register port and frame timer of a tile-video chip.
// The input channel (i_in_valid, o_in_stall, i_in_item) carries one item per
// handshake: a tick of dots, a register write, a register read or one
// sprite-memory transfer byte. The output channel (o_out_valid, i_out_stall,
// o_out_item) returns exactly one result item for every input item, in order.
// An accepted item is held in the input register, where its state update is
// done, and its result is then offered from the output register.
// One item per cycle is sustained unless the receiver stalls; the sprite
// store read is issued at the acceptance edge from the pointer value the
// preceding item leaves behind.
// Synchronous reset clears all control state, the palette and the valid bits
// of the sprite store, and sets the address toggle to expect the high byte.
// When the receiver stalls, the result is held; one further item may wait in
// the input register, after which o_in_stall is raised.
module video_register_port_and_frame_timer #(
    parameter int SPRITE_ENTRIES = 256
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  vrpft_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output vrpft_pkg::t_out_item  o_out_item
);
    import vrpft_pkg::*;

    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    logic      r_out_valid;
    logic      w_adv;
    logic      w_accept;
    t_out_item w_res;
    t_spr_wr   w_spr_wr;
    logic [7:0] w_next_ptr;
    logic [7:0] w_spr_rd;

    assign w_adv = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item = r_out;

    vrpft_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_adv),
        .i_item     (r_in),
        .i_spr_rd   (w_spr_rd),
        .o_res      (w_res),
        .o_spr_wr   (w_spr_wr),
        .o_next_ptr (w_next_ptr)
    );

    vrpft_spr_mem #(
        .SPRITE_ENTRIES (SPRITE_ENTRIES)
    ) u_spr_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_spr_wr),
        .i_rd_en   (w_accept),
        .i_rd_idx  (w_next_ptr),
        .o_rd_data (w_spr_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_out_valid)
        else $error("Processed item produced no result.");

    a_blank_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.blank_start && o_out_item.frame_done))
        else $error("Blank start and frame end in one result.");

    a_mem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.mem_write_enable) |->
            (o_out_item.mem_address < PALETTE_BASE))
        else $error("External write aimed at the palette range.");

endmodule

`default_nettype wire
